/* rtl/gcs_pkg.sv */
// Shared types and constants for the grey contrast stretch unit.
`default_nettype none

package gcs_pkg;

    localparam int MAX_ROW_WIDTH = 4096;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 13;
    localparam int PAD_W    = 2;
    localparam int COL_W    = $clog2(MAX_ROW_WIDTH);
    localparam int CNT_W    = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CMP_W    = (CNT_W > ROW_W) ? CNT_W : ROW_W;
    localparam int STEP_W   = $clog2(PIX_W);
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET   = 13'd640;
    localparam logic [PAD_W-1:0] ROW_PADDING_RESET = 2'd0;

    localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [PIX_W-1:0] LEVEL_MIN = 8'd0;

    // register select, address bit 2
    localparam logic REG_ROW_WIDTH   = 1'b0;
    localparam logic REG_ROW_PADDING = 1'b1;

    typedef enum logic [1:0] {
        CMD_BEGIN     = 2'd0,
        CMD_MEASURE   = 2'd1,
        CMD_TRANSFORM = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_img;
        logic measure;
        logic div_start;
        logic div_step;
        logic out_load;
    } gcs_ctl_t;

    typedef struct packed {
        logic div_last;
        logic out_blocked;
    } gcs_stat_t;

endpackage

`default_nettype wire

/* rtl/gcs_regs.sv */
// Configuration register file on the APB-style port.
`default_nettype none

module gcs_regs
    import gcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [ROW_W-1:0]  row_width,
    output logic [PAD_W-1:0]  row_padding
);

    logic [ROW_W-1:0] row_width_reg;
    logic [PAD_W-1:0] row_padding_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= ROW_WIDTH_RESET;
            row_padding_reg <= ROW_PADDING_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_ROW_WIDTH)
            begin
                row_width_reg <= pwdata[ROW_W-1:0];
            end
            else
            begin
                row_padding_reg <= pwdata[PAD_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_ROW_WIDTH)
        begin
            prdata = DATA_W'(row_width_reg);
        end
        else
        begin
            prdata = DATA_W'(row_padding_reg);
        end
    end

    assign row_width   = row_width_reg;
    assign row_padding = row_padding_reg;

endmodule

`default_nettype wire

/* rtl/gcs_ctrl.sv */
// Controller state machine: input handshake and divider sequencing.
`default_nettype none

module gcs_ctrl
    import gcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    input  logic [1:0] cmd,
    input  gcs_stat_t  stat,
    output logic       pix_stall,
    output gcs_ctl_t   ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid && (cmd == CMD_TRANSFORM))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        pix_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                pix_stall = 1'b0;
                if (pix_valid)
                begin
                    case (cmd)
                        CMD_BEGIN:     ctl.clear_img = 1'b1;
                        CMD_MEASURE:   ctl.measure   = 1'b1;
                        CMD_TRANSFORM: ctl.div_start = 1'b1;
                        default:       ctl           = '0;
                    endcase
                end
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.out_load = !stat.out_blocked;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/gcs_dp.sv */
// Datapath: min/max tracking, row position, restoring divider, result register.
`default_nettype none

module gcs_dp
    import gcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  gcs_ctl_t         ctl,
    input  logic [PIX_W-1:0] pixel,
    input  logic [ROW_W-1:0] row_width,
    input  logic [PAD_W-1:0] row_padding,
    input  logic             res_stall,
    output logic             res_valid,
    output logic [PIX_W-1:0] level,
    output logic             flat,
    output gcs_stat_t        stat
);

    logic [PIX_W-1:0]  lowest_reg;
    logic [PIX_W-1:0]  highest_reg;
    logic [COL_W-1:0]  column_reg;
    logic [PAD_W-1:0]  pad_left_reg;
    logic [PIX_W-1:0]  den_reg;
    logic [PIX_W-1:0]  rem_reg;
    logic [PIX_W-1:0]  dvd_reg;
    logic [PIX_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              flat_pend_reg;
    logic              zero_pend_reg;
    logic              full_pend_reg;
    logic              res_valid_reg;
    logic [PIX_W-1:0]  level_reg;
    logic              flat_reg;

    logic [CMP_W-1:0]   eff_width;
    logic [CMP_W-1:0]   col_inc;
    logic [PIX_W-1:0]   diff;
    logic [2*PIX_W-1:0] scaled;
    logic [PIX_W:0]     trial;
    logic               fits;
    logic [PIX_W:0]     trial_sub;
    logic [PIX_W-1:0]   level_next;

    // zero width counts as one pixel, oversize width saturates
    always_comb
    begin
        eff_width = CMP_W'(row_width);
        if (row_width == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (CMP_W'(row_width) > CMP_W'(MAX_ROW_WIDTH))
        begin
            eff_width = CMP_W'(MAX_ROW_WIDTH);
        end
    end

    assign col_inc = CMP_W'(column_reg) + CMP_W'(1);

    // 255*d as (d<<8)-d
    assign diff   = pixel - lowest_reg;
    assign scaled = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};

    assign trial     = {rem_reg, dvd_reg[PIX_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg   <= LEVEL_MAX;
            highest_reg  <= LEVEL_MIN;
            column_reg   <= '0;
            pad_left_reg <= '0;
        end
        else if (ctl.clear_img)
        begin
            lowest_reg   <= LEVEL_MAX;
            highest_reg  <= LEVEL_MIN;
            column_reg   <= '0;
            pad_left_reg <= '0;
        end
        else if (ctl.measure)
        begin
            if (pad_left_reg != '0)
            begin
                pad_left_reg <= pad_left_reg - PAD_W'(1);
            end
            else
            begin
                if (pixel < lowest_reg)
                begin
                    lowest_reg <= pixel;
                end
                if (pixel > highest_reg)
                begin
                    highest_reg <= pixel;
                end
                if (col_inc >= eff_width)
                begin
                    column_reg   <= '0;
                    pad_left_reg <= row_padding;
                end
                else
                begin
                    column_reg <= col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (ctl.div_start)
        begin
            step_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            den_reg       <= highest_reg - lowest_reg;
            rem_reg       <= scaled[2*PIX_W-1:PIX_W];
            dvd_reg       <= scaled[PIX_W-1:0];
            quo_reg       <= '0;
            flat_pend_reg <= highest_reg <= lowest_reg;
            zero_pend_reg <= pixel <= lowest_reg;
            full_pend_reg <= pixel >= highest_reg;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= fits ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
            dvd_reg <= {dvd_reg[PIX_W-2:0], 1'b0};
            quo_reg <= {quo_reg[PIX_W-2:0], fits};
        end
    end

    always_comb
    begin
        if (flat_pend_reg || zero_pend_reg)
        begin
            level_next = LEVEL_MIN;
        end
        else if (full_pend_reg)
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            level_reg <= level_next;
            flat_reg  <= flat_pend_reg;
        end
    end

    assign stat.div_last    = ctl.div_step && (step_reg == STEP_W'(PIX_W - 1));
    assign stat.out_blocked = res_valid_reg && res_stall;

    assign res_valid = res_valid_reg;
    assign level     = level_reg;
    assign flat      = flat_reg;

endmodule

`default_nettype wire

/* rtl/grey_contrast_stretch_unit.sv */
// Top level of the grey contrast stretch unit.
//
// Two-pass min/max contrast stretch. Send begin, then the image bytes as measure
// transfers, then the bytes again as transform transfers; each transform
// transfer returns one level = 255*(v-min)/(max-min), saturated, with flat set
// when max is not above min. Begin and measure transfers never stall the input and
// give no result. A transform transfer sets up the divider at its accepting edge
// and then holds the input stalled through the eight steps of the shared
// restoring divider and the load of the result register, longer while a
// previous result is still stalled there.
// The input side stays open while a result waits, as long as no transform is in
// progress. Registers: row_width at 0x0, row_padding at 0x4; write them only when
// the unit is idle.
`default_nettype none

module grey_contrast_stretch_unit
    import gcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic [1:0]        cmd,
    input  logic [PIX_W-1:0]  pixel,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [PIX_W-1:0]  level,
    output logic              flat,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [ROW_W-1:0] row_width;
    logic [PAD_W-1:0] row_padding;
    gcs_ctl_t         ctl;
    gcs_stat_t        stat;

    gcs_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .row_width   (row_width),
        .row_padding (row_padding)
    );

    gcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .cmd       (cmd),
        .stat      (stat),
        .pix_stall (pix_stall),
        .ctl       (ctl)
    );

    gcs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .pixel       (pixel),
        .row_width   (row_width),
        .row_padding (row_padding),
        .res_stall   (res_stall),
        .res_valid   (res_valid),
        .level       (level),
        .flat        (flat),
        .stat        (stat)
    );

endmodule

`default_nettype wire

/* rtl/gcs_checker.sv */
// Port-level checks for the grey contrast stretch unit, bound to the top level.
`default_nettype none

module gcs_checker
    import gcs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_stall,
    input logic [1:0]        cmd,
    input logic              res_valid,
    input logic              res_stall,
    input logic [PIX_W-1:0]  level,
    input logic              flat
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // a transform transfer occupies the divider
    a_busy_after_xform: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && (cmd == CMD_TRANSFORM) |=> pix_stall)
        else $error("input open right after transform transfer");

    // flat image always gives level zero
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && flat |-> level == LEVEL_MIN)
        else $error("flat result with nonzero level");

    // a new result only appears at the end of a transform, with input held off
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_stall))
        else $error("result appeared without a transform in progress");

endmodule

bind grey_contrast_stretch_unit gcs_checker u_gcs_checker (.*);

`default_nettype wire
